>>> hw/rtl/rbeuler_pkg.sv
// Shared types, constants and fixed-point helpers for the 2D rigid body Euler step block.
`timescale 1ns / 1ps

package rbeuler_pkg;

	// Body kind codes
	localparam logic [1:0] KIND_STATIC  = 2'd0;
	localparam logic [1:0] KIND_DYNAMIC = 2'd1;

	// Register indexes (byte address bits [3:2])
	localparam logic [1:0] REG_GRAVITY_X = 2'd0;
	localparam logic [1:0] REG_GRAVITY_Y = 2'd1;
	localparam logic [1:0] REG_TIME_STEP = 2'd2;

	localparam int ADDR_W = 4;
	localparam int DT_W   = 31;

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Saturation limits
	localparam logic signed [63:0] SAT_MAX64 = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] SAT_MIN64 = 64'shFFFF_FFFF_8000_0000;
	localparam logic signed [31:0] SAT_MAX32 = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAT_MIN32 = 32'sh8000_0000;

	typedef struct packed {
		logic [1:0]         body_kind;
		logic               active;
		logic signed [31:0] mass;
		logic signed [31:0] gravity_scale;
		logic signed [31:0] damping;
		logic signed [31:0] vel_x_in;
		logic signed [31:0] vel_y_in;
		logic signed [31:0] spin_rate;
		logic               lock_rotation;
		logic signed [31:0] pos_x_in;
		logic signed [31:0] pos_y_in;
		logic signed [31:0] angle_in;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] vel_x_out;
		logic signed [31:0] vel_y_out;
		logic signed [31:0] pos_x_out;
		logic signed [31:0] pos_y_out;
		logic signed [31:0] angle_out;
		logic               updated;
	} out_item_t;

	// Classification flags set by the front
	typedef struct packed {
		logic upd;      // body gets integrated
		logic dyn;      // gravity and damping apply
		logic damp_on;  // damping is positive
		logic lock;     // angle held
	} ctrl_t;

	// Queue entry: classified body
	typedef struct packed {
		ctrl_t              c;
		logic signed [31:0] gs;
		logic signed [31:0] dmp;
		logic signed [31:0] spin;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] ang;
	} q_item_t;

	// Back pipeline stage contents
	typedef struct packed {
		ctrl_t              c;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] ang;
		logic signed [31:0] sdt;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic signed [31:0] tk;
	} work_t;

	// Fixed-point product: exact, floor shift, saturate
	function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
			input logic signed [31:0] b, input int unsigned fb);
		logic signed [63:0] p;
		logic signed [63:0] s;
		p = 64'(a) * 64'(b);
		s = p >>> fb;
		if (s > SAT_MAX64) begin
			return SAT_MAX32;
		end else if (s < SAT_MIN64) begin
			return SAT_MIN32;
		end
		return signed'(s[31:0]);
	endfunction

	// Saturating add
	function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		if (s[32] != s[31]) begin
			return s[32] ? SAT_MIN32 : SAT_MAX32;
		end
		return signed'(s[31:0]);
	endfunction

endpackage

>>> hw/rtl/rigid_body_euler_step_2d_top.sv
// Top level of the 2D rigid body semi-implicit Euler step block.
// Path to out_valid: front register, queue write, then six back stages;
// an output stall holds it. Throughput: one body per cycle unless stalled;
// the back spreads ten 32x32 multipliers over four of its six stages.
// The four-entry queue absorbs front/back skew.
// Reset clears all valid flags, queue pointers and the registers to zero.
`timescale 1ns / 1ps

module rigid_body_euler_step_2d_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  rbeuler_pkg::in_item_t             in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output rbeuler_pkg::out_item_t            out_data,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rbeuler_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	logic signed [31:0]           gx_q;
	logic signed [31:0]           gy_q;
	logic [rbeuler_pkg::DT_W-1:0] dt_q;
	logic                         cfg_wr;

	logic                 push, pop, q_empty, q_full;
	rbeuler_pkg::q_item_t push_data, pop_data;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gx_q <= '0;
			gy_q <= '0;
			dt_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				rbeuler_pkg::REG_GRAVITY_X: gx_q <= signed'(pwdata);
				rbeuler_pkg::REG_GRAVITY_Y: gy_q <= signed'(pwdata);
				rbeuler_pkg::REG_TIME_STEP: dt_q <= pwdata[rbeuler_pkg::DT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			rbeuler_pkg::REG_GRAVITY_X: prdata = gx_q;
			rbeuler_pkg::REG_GRAVITY_Y: prdata = gy_q;
			rbeuler_pkg::REG_TIME_STEP: prdata = {1'b0, dt_q};
			default:                    prdata = '0;
		endcase
	end

	rbeuler_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.dt        (dt_q),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	rbeuler_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty),
		.full      (q_full)
	);

	rbeuler_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (!q_empty),
		.q_data    (pop_data),
		.q_pop     (pop),
		.gx        (gx_q),
		.gy        (gy_q),
		.dt        (dt_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_zero_step_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (dt_q == '0)) |-> !out_data.updated)
		else $error("body updated with zero time step");

endmodule

>>> hw/rtl/rbeuler_front.sv
// Front: accepts bodies, classifies them and pushes them into the queue.
`timescale 1ns / 1ps

module rbeuler_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  rbeuler_pkg::in_item_t    in_data,
	input  logic [rbeuler_pkg::DT_W-1:0] dt,
	output logic                     push,
	output rbeuler_pkg::q_item_t     push_data,
	input  logic                     q_full
);

	logic                 fr_v_q;
	rbeuler_pkg::q_item_t fr_q;
	rbeuler_pkg::q_item_t cls;
	logic                 load;

	// Classification
	always_comb begin
		cls.c.upd     = (dt != '0) && in_data.active &&
		                (in_data.body_kind != rbeuler_pkg::KIND_STATIC) &&
		                !((in_data.body_kind == rbeuler_pkg::KIND_DYNAMIC) &&
		                  ($signed(in_data.mass) <= 32'sd0));
		cls.c.dyn     = (in_data.body_kind == rbeuler_pkg::KIND_DYNAMIC);
		cls.c.damp_on = ($signed(in_data.damping) > 32'sd0);
		cls.c.lock    = in_data.lock_rotation;
		cls.gs        = in_data.gravity_scale;
		cls.dmp       = in_data.damping;
		cls.spin      = in_data.spin_rate;
		cls.vx        = in_data.vel_x_in;
		cls.vy        = in_data.vel_y_in;
		cls.px        = in_data.pos_x_in;
		cls.py        = in_data.pos_y_in;
		cls.ang       = in_data.angle_in;
	end

	// Hand-off: stall only when holding a transaction the queue cannot take
	assign push      = fr_v_q && !q_full;
	assign in_stall  = fr_v_q && q_full;
	assign load      = in_valid && !in_stall;
	assign push_data = fr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_v_q <= 1'b0;
		end else if (load) begin
			fr_v_q <= 1'b1;
		end else if (push) begin
			fr_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			fr_q <= cls;
		end
	end

endmodule

>>> hw/rtl/rbeuler_queue.sv
// Short queue decoupling the front from the arithmetic back.
`timescale 1ns / 1ps

module rbeuler_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rbeuler_pkg::q_item_t push_data,
	input  logic                 pop,
	output rbeuler_pkg::q_item_t pop_data,
	output logic                 empty,
	output logic                 full
);

	rbeuler_pkg::q_item_t             mem_q [rbeuler_pkg::QDEPTH];
	logic [rbeuler_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [rbeuler_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [rbeuler_pkg::QCNT_W-1:0]   cnt_q;

	assign empty    = (cnt_q == '0);
	assign full     = (cnt_q == rbeuler_pkg::QCNT_W'(rbeuler_pkg::QDEPTH));
	assign pop_data = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue pop while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rbeuler_pkg::QCNT_W'(rbeuler_pkg::QDEPTH))
		else $error("queue count out of range");

endmodule

>>> hw/rtl/rbeuler_back.sv
// Back: six-stage fixed-point pipeline doing gravity, damping and integration.
`timescale 1ns / 1ps

module rbeuler_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  rbeuler_pkg::q_item_t      q_data,
	output logic                      q_pop,
	input  logic signed [31:0]        gx,
	input  logic signed [31:0]        gy,
	input  logic [rbeuler_pkg::DT_W-1:0] dt,
	output logic                      out_valid,
	input  logic                      out_stall,
	output rbeuler_pkg::out_item_t    out_data
);

	localparam logic signed [32:0] ONE = 33'sd1 <<< FRAC_BITS;

	logic               adv;
	logic signed [31:0] dts;
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	rbeuler_pkg::work_t w_s1, w_s2, w_s3, w_s4, w_s5, w_s6;
	rbeuler_pkg::work_t s1_d, s2_d, s3_d, s4_d, s5_d, s6_d;
	logic signed [32:0] fac;

	assign dts   = signed'({1'b0, dt});
	assign adv   = !(v_s6 && out_stall);
	assign q_pop = adv && q_valid;

	// s1: gravity * scale, damping * dt, spin * dt
	always_comb begin
		s1_d.c   = q_data.c;
		s1_d.vx  = q_data.vx;
		s1_d.vy  = q_data.vy;
		s1_d.px  = q_data.px;
		s1_d.py  = q_data.py;
		s1_d.ang = q_data.ang;
		s1_d.tx  = rbeuler_pkg::qmul(gx, q_data.gs, FRAC_BITS);
		s1_d.ty  = rbeuler_pkg::qmul(gy, q_data.gs, FRAC_BITS);
		s1_d.tk  = rbeuler_pkg::qmul(q_data.dmp, dts, FRAC_BITS);
		s1_d.sdt = rbeuler_pkg::qmul(q_data.spin, dts, FRAC_BITS);
	end

	// s2: velocity gain, damping factor, angle update
	always_comb begin
		fac     = ONE - 33'(w_s1.tk);
		s2_d    = w_s1;
		s2_d.tx = rbeuler_pkg::qmul(w_s1.tx, dts, FRAC_BITS);
		s2_d.ty = rbeuler_pkg::qmul(w_s1.ty, dts, FRAC_BITS);
		s2_d.tk = (fac < 33'sd0) ? 32'sd0 : signed'(fac[31:0]);
		if (w_s1.c.upd && !w_s1.c.lock) begin
			s2_d.ang = rbeuler_pkg::qadd(w_s1.ang, w_s1.sdt);
		end
	end

	// s3: add gravity gain to velocity
	always_comb begin
		s3_d = w_s2;
		if (w_s2.c.upd && w_s2.c.dyn) begin
			s3_d.vx = rbeuler_pkg::qadd(w_s2.vx, w_s2.tx);
			s3_d.vy = rbeuler_pkg::qadd(w_s2.vy, w_s2.ty);
		end
	end

	// s4: damping
	always_comb begin
		s4_d = w_s3;
		if (w_s3.c.upd && w_s3.c.dyn && w_s3.c.damp_on) begin
			s4_d.vx = rbeuler_pkg::qmul(w_s3.vx, w_s3.tk, FRAC_BITS);
			s4_d.vy = rbeuler_pkg::qmul(w_s3.vy, w_s3.tk, FRAC_BITS);
		end
	end

	// s5: displacement
	always_comb begin
		s5_d    = w_s4;
		s5_d.tx = rbeuler_pkg::qmul(w_s4.vx, dts, FRAC_BITS);
		s5_d.ty = rbeuler_pkg::qmul(w_s4.vy, dts, FRAC_BITS);
	end

	// s6: position update, output register
	always_comb begin
		s6_d = w_s5;
		if (w_s5.c.upd) begin
			s6_d.px = rbeuler_pkg::qadd(w_s5.px, w_s5.tx);
			s6_d.py = rbeuler_pkg::qadd(w_s5.py, w_s5.ty);
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1 <= s1_d;
			w_s2 <= s2_d;
			w_s3 <= s3_d;
			w_s4 <= s4_d;
			w_s5 <= s5_d;
			w_s6 <= s6_d;
		end
	end

	assign out_valid          = v_s6;
	assign out_data.vel_x_out = w_s6.vx;
	assign out_data.vel_y_out = w_s6.vy;
	assign out_data.pos_x_out = w_s6.px;
	assign out_data.pos_y_out = w_s6.py;
	assign out_data.angle_out = w_s6.ang;
	assign out_data.updated   = w_s6.c.upd;

	a_pop_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> v_s1) else $error("popped transaction lost at first stage");

endmodule

>>> tb/rigid_body_euler_step_2d_top_test.sv
// Self-checking testbench for the 2D rigid body Euler step block: APB setup, streamed bodies.
`timescale 1ns / 1ps

module rigid_body_euler_step_2d_top_test;

	localparam int FRAC = 16;
	localparam int RESET_CYCLES = 11;
	localparam int SETTLE_CYCLES = 12;     // block latency plus margin
	localparam int LONG_HOLD = 100;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_BODIES = 150;

	localparam logic [1:0] KIND_KINEMATIC = 2'd2;
	localparam logic [1:0] KIND_SPARE     = 2'd3;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	rbeuler_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rbeuler_pkg::out_item_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [rbeuler_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	rigid_body_euler_step_2d_top #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Local copy of the register file
	logic signed [31:0] grav_x = '0;
	logic signed [31:0] grav_y = '0;
	logic [30:0] step_dt = '0;

	rbeuler_pkg::in_item_t pending_bodies[$];
	rbeuler_pkg::out_item_t body_results_due[$];

	int errors = 0;
	int cycle_count = 0;
	int tx_gap_max = 3;
	int tx_gap_left = 0;
	bit presenting = 1'b0;
	int rx_stall_max = 3;
	int rx_stall_left = 0;
	int rx_hold_left = 0;
	int rx_draw;
	int hold_requests = 0;
	int hold_served = 0;

	// Clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("rigid_body_euler_step_2d_top test failed");
			$finish;
		end
	end

	// Fixed-point product: exact, floor shift, saturate
	function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] prod;
		logic signed [63:0] shifted;
		prod = $signed({{32{a[31]}}, a}) * b;
		shifted = prod >>> FRAC;
		if (shifted > 64'sh0000_0000_7FFF_FFFF)
			return rbeuler_pkg::SAT_MAX32;
		if (shifted < -64'sh0000_0000_8000_0000)
			return rbeuler_pkg::SAT_MIN32;
		return shifted[31:0];
	endfunction

	// Saturating sum
	function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = $signed({a[31], a}) + $signed({b[31], b});
		if (s[32] != s[31])
			return s[32] ? rbeuler_pkg::SAT_MIN32 : rbeuler_pkg::SAT_MAX32;
		return s[31:0];
	endfunction

	// One semi-implicit Euler step of a body under the current registers
	function automatic rbeuler_pkg::out_item_t integrate_body(input rbeuler_pkg::in_item_t b);
		rbeuler_pkg::out_item_t r;
		logic signed [31:0] vx, vy, px, py, ang, damp_dt;
		logic signed [63:0] dt64, factor;
		logic moves;
		vx = b.vel_x_in;
		vy = b.vel_y_in;
		px = b.pos_x_in;
		py = b.pos_y_in;
		ang = b.angle_in;
		dt64 = {33'd0, step_dt};
		moves = (step_dt != '0) && b.active && (b.body_kind != rbeuler_pkg::KIND_STATIC) &&
			!(b.body_kind == rbeuler_pkg::KIND_DYNAMIC && $signed(b.mass) <= 32'sd0);
		if (moves) begin
			if (b.body_kind == rbeuler_pkg::KIND_DYNAMIC) begin
				vx = fx_add(vx, fx_mul(fx_mul(grav_x, b.gravity_scale), dt64));
				vy = fx_add(vy, fx_mul(fx_mul(grav_y, b.gravity_scale), dt64));
				if ($signed(b.damping) > 32'sd0) begin
					damp_dt = fx_mul(b.damping, dt64);
					factor = (64'sd1 <<< FRAC) - damp_dt;
					if (factor < 0)
						factor = 0;
					vx = fx_mul(vx, factor);
					vy = fx_mul(vy, factor);
				end
			end
			px = fx_add(px, fx_mul(vx, dt64));
			py = fx_add(py, fx_mul(vy, dt64));
			if (!b.lock_rotation)
				ang = fx_add(ang, fx_mul(b.spin_rate, dt64));
		end
		r.vel_x_out = vx;
		r.vel_y_out = vy;
		r.pos_x_out = px;
		r.pos_y_out = py;
		r.angle_out = ang;
		r.updated = moves;
		return r;
	endfunction

	// Driver: present queued bodies, random gap before each next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				body_results_due.push_back(integrate_body(in_data));
				presenting = 1'b0;
			end
			if (!presenting) begin
				if (tx_gap_left > 0) begin
					tx_gap_left = tx_gap_left - 1;
				end else if (pending_bodies.size() > 0) begin
					in_data <= pending_bodies.pop_front();
					presenting = 1'b1;
					tx_gap_left = $urandom_range(0, tx_gap_max);
				end
			end
			in_valid <= presenting;
		end
	end

	task automatic flag_field(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, label, want, got);
		end
	endtask

	// Monitor: check each result transaction, draw stall, serve long holds
	always @(posedge clk) begin
		if (arst_n) begin
			rx_draw = rx_stall_left;
			if (out_valid && !out_stall) begin
				if (body_results_due.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected result, expected none, got %h",
						$time, out_data);
				end else begin
					rbeuler_pkg::out_item_t want;
					want = body_results_due.pop_front();
					flag_field("vel_x_out", want.vel_x_out, out_data.vel_x_out);
					flag_field("vel_y_out", want.vel_y_out, out_data.vel_y_out);
					flag_field("pos_x_out", want.pos_x_out, out_data.pos_x_out);
					flag_field("pos_y_out", want.pos_y_out, out_data.pos_y_out);
					flag_field("angle_out", want.angle_out, out_data.angle_out);
					flag_field("updated", 32'(want.updated), 32'(out_data.updated));
				end
				rx_draw = $urandom_range(0, rx_stall_max);
			end
			if (hold_served != hold_requests) begin
				hold_served++;
				rx_hold_left = LONG_HOLD;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				out_stall <= 1'b1;
			end else if (rx_draw > 0) begin
				rx_stall_left = rx_draw - 1;
				out_stall <= 1'b1;
			end else begin
				rx_stall_left = 0;
				out_stall <= 1'b0;
			end
		end
	end

	// APB write: setup then access; register takes it at the access edge
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			rbeuler_pkg::REG_GRAVITY_X: grav_x = value;
			rbeuler_pkg::REG_GRAVITY_Y: grav_y = value;
			rbeuler_pkg::REG_TIME_STEP: step_dt = value[30:0];
			default: ;
		endcase
	endtask

	task automatic set_world(input logic [31:0] gx, input logic [31:0] gy,
			input logic [31:0] dt_word);
		write_reg(rbeuler_pkg::REG_GRAVITY_X, gx);
		write_reg(rbeuler_pkg::REG_GRAVITY_Y, gy);
		write_reg(rbeuler_pkg::REG_TIME_STEP, dt_word);
		@(negedge clk);
	endtask

	// Wait until every body is through, then let the pipeline settle
	task automatic drain();
		do @(negedge clk);
		while (pending_bodies.size() != 0 || presenting || body_results_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic rbeuler_pkg::in_item_t make_body(input logic [1:0] kind,
			input logic act,
			input logic [31:0] mass, input logic [31:0] gs, input logic [31:0] damp,
			input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] spin,
			input logic lock, input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] ang);
		rbeuler_pkg::in_item_t b;
		b.body_kind = kind;
		b.active = act;
		b.mass = mass;
		b.gravity_scale = gs;
		b.damping = damp;
		b.vel_x_in = vx;
		b.vel_y_in = vy;
		b.spin_rate = spin;
		b.lock_rotation = lock;
		b.pos_x_in = px;
		b.pos_y_in = py;
		b.angle_in = ang;
		return b;
	endfunction

	// Q16.16 value: full random, modest magnitude, or an edge value
	function automatic logic [31:0] rand_q();
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick < 7)
			return $urandom;
		if (pick < 17)
			return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
		case ($urandom_range(0, 4))
			0: return rbeuler_pkg::SAT_MAX32;
			1: return rbeuler_pkg::SAT_MIN32;
			2: return 32'h0;
			3: return 32'h1;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [31:0] rand_dt_word();
		int unsigned pick;
		logic [30:0] dt;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			dt = 31'($urandom_range(1, 32'h4000));
		else if (pick < 8)
			dt = 31'($urandom_range(32'h4000, 32'h4_0000));
		else if (pick < 9)
			dt = 31'($urandom);
		else
			dt = 31'h7FFF_FFFF;
		return {1'($urandom_range(0, 1)), dt};
	endfunction

	// Mostly plausible bodies with random content, some pure noise
	function automatic rbeuler_pkg::in_item_t random_body();
		rbeuler_pkg::in_item_t b;
		int unsigned k;
		if ($urandom_range(0, 9) == 0) begin
			return make_body(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom,
				1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
		end
		k = $urandom_range(0, 19);
		if (k < 2)
			b.body_kind = rbeuler_pkg::KIND_STATIC;
		else if (k < 12)
			b.body_kind = rbeuler_pkg::KIND_DYNAMIC;
		else if (k < 18)
			b.body_kind = KIND_KINEMATIC;
		else
			b.body_kind = KIND_SPARE;
		b.active = ($urandom_range(0, 9) != 0);
		b.mass = ($urandom_range(0, 5) == 0) ? rand_q() : 32'($urandom_range(1, 32'h0100_0000));
		b.gravity_scale = $urandom_range(0, 1) ? ONE : rand_q();
		b.damping = $urandom_range(0, 1) ? 32'($urandom_range(0, 32'h0002_0000)) : rand_q();
		b.vel_x_in = rand_q();
		b.vel_y_in = rand_q();
		b.spin_rate = rand_q();
		b.lock_rotation = 1'($urandom_range(0, 1));
		b.pos_x_in = rand_q();
		b.pos_y_in = rand_q();
		b.angle_in = rand_q();
		return b;
	endfunction

	// Sequencer: reset, directed bodies, random phases over several settings
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset registers: zero step, every body passes through
		pending_bodies.push_back(make_body(rbeuler_pkg::KIND_DYNAMIC, 1'b1, ONE, ONE,
			32'h0000_8000, 32'h0002_0000, 32'hFFFD_0000, ONE, 1'b0, 32'h0010_0000,
			32'h0, 32'h0));
		pending_bodies.push_back(make_body(KIND_KINEMATIC, 1'b1, ONE, ONE, 32'h0,
			rbeuler_pkg::SAT_MAX32, rbeuler_pkg::SAT_MIN32, rbeuler_pkg::SAT_MAX32, 1'b0,
			rbeuler_pkg::SAT_MAX32, rbeuler_pkg::SAT_MIN32, rbeuler_pkg::SAT_MAX32));
		pending_bodies.push_back(make_body(KIND_SPARE, 1'b1, ONE, ONE, 32'h0,
			ONE, ONE, ONE, 1'b0, ONE, ONE, ONE));
		drain();

		// Ordinary world: gravity (1.0, -9.8), step 1/60
		set_world(ONE, 32'hFFF6_3334, 32'h0000_0444);
		pending_bodies.push_back(make_body(rbeuler_pkg::KIND_STATIC, 1'b1, ONE, ONE, 32'h0,
			ONE, ONE, ONE, 1'b0, ONE, ONE, ONE));
		pending_bodies.push_back(make_body(rbeuler_pkg::KIND_DYNAMIC, 1'b0, ONE, ONE, 32'h0,
			ONE, ONE, ONE, 1'b0, ONE, ONE, ONE));
		pending_bodies.push_back(make_body(rbeuler_pkg::KIND_DYNAMIC, 1'b1, 32'h0, ONE,
			32'h0, ONE, ONE, ONE, 1'b0, ONE, ONE, ONE));
		pending_bodies.push_back(make_body(rbeuler_pkg::KIND_DYNAMIC, 1'b1,
			rbeuler_pkg::SAT_MIN32, ONE, 32'h0, ONE, ONE, ONE, 1'b0, ONE, ONE, ONE));
		pending_bodies.push_back(make_body(rbeuler_pkg::KIND_DYNAMIC, 1'b1, ONE, ONE, 32'h0,
			32'h0002_0000, 32'hFFFD_0000, 32'h0001_8000, 1'b0, 32'h0005_0000,
			32'hFFF0_0000, 32'h0000_4000));
		pending_bodies.push_back(make_body(rbeuler_pkg::KIND_DYNAMIC, 1'b1, ONE, ONE,
			32'h0000_8000, 32'h0002_0000, 32'hFFFD_0000, ONE, 1'b0, ONE, ONE, ONE));
		// damping so large that the factor clamps at zero
		pending_bodies.push_back(make_body(rbeuler_pkg::KIND_DYNAMIC, 1'b1, ONE, ONE,
			rbeuler_pkg::SAT_MAX32, 32'h0002_0000, 32'hFFFD_0000, ONE, 1'b0,
			ONE, ONE, ONE));
		pending_bodies.push_back(make_body(rbeuler_pkg::KIND_DYNAMIC, 1'b1, ONE, ONE,
			rbeuler_pkg::SAT_MIN32, 32'h0002_0000, 32'hFFFD_0000, ONE, 1'b0,
			ONE, ONE, ONE));
		pending_bodies.push_back(make_body(rbeuler_pkg::KIND_DYNAMIC, 1'b1, ONE, ONE, 32'h0,
			ONE, ONE, 32'h0004_0000, 1'b1, ONE, ONE, 32'h0003_0000));
		pending_bodies.push_back(make_body(KIND_KINEMATIC, 1'b1, 32'h0, ONE, ONE,
			32'h0003_0000, 32'hFFFF_0000, 32'h0002_0000, 1'b0, ONE, ONE, ONE));
		pending_bodies.push_back(make_body(KIND_SPARE, 1'b1, rbeuler_pkg::SAT_MIN32, ONE, ONE,
			32'h0003_0000, 32'hFFFF_0000, 32'h0002_0000, 1'b0, ONE, ONE, ONE));
		pending_bodies.push_back(make_body(KIND_KINEMATIC, 1'b0, ONE, ONE, ONE,
			32'h0003_0000, 32'hFFFF_0000, 32'h0002_0000, 1'b0, ONE, ONE, ONE));
		drain();

		// Extreme world: saturation everywhere
		set_world(rbeuler_pkg::SAT_MAX32, rbeuler_pkg::SAT_MIN32, 32'h7FFF_FFFF);
		pending_bodies.push_back(make_body(rbeuler_pkg::KIND_DYNAMIC, 1'b1, ONE,
			rbeuler_pkg::SAT_MAX32, 32'h0, rbeuler_pkg::SAT_MAX32, rbeuler_pkg::SAT_MIN32,
			rbeuler_pkg::SAT_MAX32, 1'b0, rbeuler_pkg::SAT_MAX32, rbeuler_pkg::SAT_MIN32,
			rbeuler_pkg::SAT_MAX32));
		pending_bodies.push_back(make_body(rbeuler_pkg::KIND_DYNAMIC, 1'b1,
			rbeuler_pkg::SAT_MAX32, rbeuler_pkg::SAT_MIN32, 32'h0, 32'h0, 32'h0,
			rbeuler_pkg::SAT_MIN32, 1'b0, rbeuler_pkg::SAT_MIN32, rbeuler_pkg::SAT_MAX32,
			rbeuler_pkg::SAT_MIN32));
		pending_bodies.push_back(make_body(KIND_KINEMATIC, 1'b1, ONE, ONE, 32'h0,
			rbeuler_pkg::SAT_MAX32, rbeuler_pkg::SAT_MAX32, rbeuler_pkg::SAT_MAX32, 1'b0,
			rbeuler_pkg::SAT_MIN32, rbeuler_pkg::SAT_MIN32, rbeuler_pkg::SAT_MAX32));
		pending_bodies.push_back(make_body(KIND_KINEMATIC, 1'b1, ONE, ONE, 32'h0,
			rbeuler_pkg::SAT_MIN32, rbeuler_pkg::SAT_MIN32, rbeuler_pkg::SAT_MIN32, 1'b0,
			rbeuler_pkg::SAT_MAX32, rbeuler_pkg::SAT_MAX32, rbeuler_pkg::SAT_MIN32));
		pending_bodies.push_back(make_body(rbeuler_pkg::KIND_DYNAMIC, 1'b1,
			rbeuler_pkg::SAT_MAX32, 32'h0, 32'h1, 32'h0001_0000, 32'hFFFF_0000, ONE, 1'b1,
			ONE, ONE, ONE));
		pending_bodies.push_back(make_body(rbeuler_pkg::KIND_STATIC, 1'b1,
			rbeuler_pkg::SAT_MAX32, rbeuler_pkg::SAT_MAX32, rbeuler_pkg::SAT_MAX32,
			rbeuler_pkg::SAT_MAX32, rbeuler_pkg::SAT_MAX32, rbeuler_pkg::SAT_MAX32, 1'b1,
			rbeuler_pkg::SAT_MAX32, rbeuler_pkg::SAT_MAX32, rbeuler_pkg::SAT_MAX32));
		drain();

		// Random phases, each with its own world and traffic profile
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: set_world(rbeuler_pkg::SAT_MIN32, rbeuler_pkg::SAT_MAX32, 32'h0000_0001);
				1: set_world(rand_q(), rand_q(), 32'h8000_0000);
				default: set_world(rand_q(), rand_q(), rand_dt_word());
			endcase
			tx_gap_max = (phase == 3 || phase == 4) ? 0 : 3;
			rx_stall_max = (phase == 3) ? 0 : 3;
			for (int n = 0; n < PHASE_BODIES; n++)
				pending_bodies.push_back(random_body());
			// receiver holds off while the sender keeps offering
			if (phase == 4)
				hold_requests++;
			drain();
		end

		if (errors == 0) begin
			$display("rigid_body_euler_step_2d_top test passed");
		end else begin
			$display("rigid_body_euler_step_2d_top test failed");
		end
		$finish;
	end

endmodule

>>> rigid_body_euler_step_2d_top.f
hw/rtl/rbeuler_pkg.sv
hw/rtl/rbeuler_front.sv
hw/rtl/rbeuler_queue.sv
hw/rtl/rbeuler_back.sv
hw/rtl/rigid_body_euler_step_2d_top.sv
tb/rigid_body_euler_step_2d_top_test.sv
